@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the reverb RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define SCAR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define SCAR_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/core/scar_pkg.sv @@
// Types, constants, preset ROM and microcode decode for the stereo reverb.
package scar_pkg;

    localparam int ADDR_W = 15;
    localparam int BUFFER_DEPTH = 32768;
    localparam int NUM_PRESETS = 7;

    localparam logic [1:0] REG_PRESET = 2'd0;
    localparam logic [1:0] REG_GAIN_L = 2'd1;
    localparam logic [1:0] REG_GAIN_R = 2'd2;

    localparam logic [4:0] R_DAPF1  = 5'h00;
    localparam logic [4:0] R_DAPF2  = 5'h01;
    localparam logic [4:0] R_VIIR   = 5'h02;
    localparam logic [4:0] R_VC1    = 5'h03;
    localparam logic [4:0] R_VWALL  = 5'h07;
    localparam logic [4:0] R_VAPF1  = 5'h08;
    localparam logic [4:0] R_VAPF2  = 5'h09;
    localparam logic [4:0] R_MLSAME = 5'h0a;
    localparam logic [4:0] R_MRSAME = 5'h0b;
    localparam logic [4:0] R_MLC1   = 5'h0c;
    localparam logic [4:0] R_MLC2   = 5'h0e;
    localparam logic [4:0] R_DLSAME = 5'h10;
    localparam logic [4:0] R_DRSAME = 5'h11;
    localparam logic [4:0] R_MLDIFF = 5'h12;
    localparam logic [4:0] R_MRDIFF = 5'h13;
    localparam logic [4:0] R_MLC3   = 5'h14;
    localparam logic [4:0] R_MLC4   = 5'h16;
    localparam logic [4:0] R_DLDIFF = 5'h18;
    localparam logic [4:0] R_DRDIFF = 5'h19;
    localparam logic [4:0] R_MLAPF1 = 5'h1a;
    localparam logic [4:0] R_MRAPF1 = 5'h1b;
    localparam logic [4:0] R_MLAPF2 = 5'h1c;
    localparam logic [4:0] R_MRAPF2 = 5'h1d;
    localparam logic [4:0] R_VLIN   = 5'h1e;
    localparam logic [4:0] R_VRIN   = 5'h1f;

    localparam logic [15:0] ROM_WORDS [0:NUM_PRESETS-1][0:31] = '{
        '{16'h007d, 16'h005b, 16'h6d80, 16'h54b8, 16'hbed0, 16'h0000, 16'h0000, 16'hba80,
          16'h5800, 16'h5300, 16'h04d6, 16'h0333, 16'h03f0, 16'h0227, 16'h0374, 16'h01ef,
          16'h0334, 16'h01b5, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
          16'h0000, 16'h0000, 16'h01b4, 16'h0136, 16'h00b8, 16'h005c, 16'h8000, 16'h8000},
        '{16'h0033, 16'h0025, 16'h70f0, 16'h4fa8, 16'hbce0, 16'h4410, 16'hc0f0, 16'h9c00,
          16'h5280, 16'h4ec0, 16'h03e4, 16'h031b, 16'h03a4, 16'h02af, 16'h0372, 16'h0266,
          16'h031c, 16'h025d, 16'h025c, 16'h018e, 16'h022f, 16'h0135, 16'h01d2, 16'h00b7,
          16'h018f, 16'h00b5, 16'h00b4, 16'h0080, 16'h004c, 16'h0026, 16'h8000, 16'h8000},
        '{16'h00b1, 16'h007f, 16'h70f0, 16'h4fa8, 16'hbce0, 16'h4510, 16'hbef0, 16'hb4c0,
          16'h5280, 16'h4ec0, 16'h0904, 16'h076b, 16'h0824, 16'h065f, 16'h07a2, 16'h0616,
          16'h076c, 16'h05ed, 16'h05ec, 16'h042e, 16'h050f, 16'h0305, 16'h0462, 16'h02b7,
          16'h042f, 16'h0265, 16'h0264, 16'h01b2, 16'h0100, 16'h0080, 16'h8000, 16'h8000},
        '{16'h00e3, 16'h00a9, 16'h6f60, 16'h4fa8, 16'hbce0, 16'h4510, 16'hbef0, 16'ha680,
          16'h5680, 16'h52c0, 16'h0dfb, 16'h0b58, 16'h0d09, 16'h0a3c, 16'h0bd9, 16'h0973,
          16'h0b59, 16'h08da, 16'h08d9, 16'h05e9, 16'h07ec, 16'h04b0, 16'h06ef, 16'h03d2,
          16'h05ea, 16'h031d, 16'h031c, 16'h0238, 16'h0154, 16'h00aa, 16'h8000, 16'h8000},
        '{16'h01a5, 16'h0139, 16'h6000, 16'h5000, 16'h4c00, 16'hb800, 16'hbc00, 16'hc000,
          16'h6000, 16'h5c00, 16'h15ba, 16'h11bb, 16'h14c2, 16'h10bd, 16'h11bc, 16'h0dc1,
          16'h11c0, 16'h0dc3, 16'h0dc0, 16'h09c1, 16'h0bc4, 16'h07c1, 16'h0a00, 16'h06cd,
          16'h09c2, 16'h05c1, 16'h05c0, 16'h041a, 16'h0274, 16'h013a, 16'h8000, 16'h8000},
        '{16'h0017, 16'h0013, 16'h70f0, 16'h4fa8, 16'hbce0, 16'h4510, 16'hbef0, 16'h8500,
          16'h5f80, 16'h54c0, 16'h0371, 16'h02af, 16'h02e5, 16'h01df, 16'h02b0, 16'h01d7,
          16'h0358, 16'h026a, 16'h01d6, 16'h011e, 16'h012d, 16'h00b1, 16'h011f, 16'h0059,
          16'h01a0, 16'h00e3, 16'h0058, 16'h0040, 16'h0028, 16'h0014, 16'h8000, 16'h8000},
        '{16'h033d, 16'h0231, 16'h7e00, 16'h5000, 16'hb400, 16'hb000, 16'h4c00, 16'hb000,
          16'h6000, 16'h5400, 16'h1ed6, 16'h1a31, 16'h1d14, 16'h183b, 16'h1bc2, 16'h16b2,
          16'h1a32, 16'h15ef, 16'h15ee, 16'h1055, 16'h1334, 16'h0f2d, 16'h11f6, 16'h0c5d,
          16'h1056, 16'h0ae1, 16'h0ae0, 16'h07a2, 16'h0464, 16'h0232, 16'h8000, 16'h8000}
    };

    localparam logic [ADDR_W-1:0] ROM_SIZE [0:NUM_PRESETS-1] = '{
        ADDR_W'(32'h026c0 / 2), ADDR_W'(32'h01f40 / 2), ADDR_W'(32'h04840 / 2),
        ADDR_W'(32'h06fe0 / 2), ADDR_W'(32'h0ade0 / 2), ADDR_W'(32'h03c00 / 2),
        ADDR_W'(32'h0f6c0 / 2)
    };

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

    typedef enum logic [3:0] {
        U_IN, U_SAME_L, U_SAME_R, U_DIFF_L, U_DIFF_R, U_COMB_L, U_COMB_R,
        U_AP1_L, U_AP1_R, U_AP2_L, U_AP2_R, U_OUT
    } unit_t;

    typedef enum logic [1:0] {M_NONE, M_RD, M_WR} mop_t;

    typedef enum logic [1:0] {O_PLAIN, O_DEC, O_AP1, O_AP2} omode_t;

    typedef enum logic [3:0] {
        A_NONE, A_MUL_IN, A_SET_IN, A_MUL_RV, A_MUL_X, A_MUL_G, A_PV,
        A_X_IN_M_PV, A_X_M_PV, A_X_CLR, A_X_ADD_M, A_X_SUB_M, A_X_M_RV, A_OUT
    } alu_t;

    typedef struct packed {
        mop_t        mop;
        alu_t        alu;
        logic        side;
        logic [4:0]  rsel;
        omode_t      om;
    } uop_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [15:0]       wdata;
    } wbuf_req_t;

    function automatic logic [3:0] last_sub(unit_t u);
        unique case (u)
            U_IN, U_OUT:         return 4'd3;
            U_COMB_L, U_COMB_R:  return 4'd8;
            default:             return 4'd6;
        endcase
    endfunction

    function automatic logic signed [15:0] sat16(logic signed [23:0] v);
        if (v > 24'sd32767)
            return 16'sh7fff;
        else if (v < -24'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

    function automatic uop_t decode(unit_t u, logic [3:0] sub);
        uop_t       op;
        logic [4:0] mp;
        logic [4:0] dr;
        logic [4:0] tap;
        logic [4:0] vap;
        omode_t     apm;
        op.mop  = M_NONE;
        op.alu  = A_NONE;
        op.side = 1'b0;
        op.rsel = R_DAPF1;
        op.om   = O_PLAIN;
        mp      = R_MLSAME;
        dr      = R_DLSAME;
        vap     = R_VAPF1;
        apm     = O_AP1;
        unique case (u)
            U_SAME_L: begin mp = R_MLSAME; dr = R_DLSAME; end
            U_SAME_R: begin mp = R_MRSAME; dr = R_DRSAME; op.side = 1'b1; end
            U_DIFF_L: begin mp = R_MLDIFF; dr = R_DRDIFF; end
            U_DIFF_R: begin mp = R_MRDIFF; dr = R_DLDIFF; op.side = 1'b1; end
            U_AP1_L:  begin mp = R_MLAPF1; end
            U_AP1_R:  begin mp = R_MRAPF1; op.side = 1'b1; end
            U_AP2_L:  begin mp = R_MLAPF2; vap = R_VAPF2; apm = O_AP2; end
            U_AP2_R:  begin mp = R_MRAPF2; vap = R_VAPF2; apm = O_AP2; op.side = 1'b1; end
            U_COMB_L: op.side = 1'b0;
            U_COMB_R: op.side = 1'b1;
            default:  op.side = sub[1];
        endcase
        unique case (sub[2:1])
            2'd0:    tap = R_MLC1;
            2'd1:    tap = R_MLC2;
            2'd2:    tap = R_MLC3;
            default: tap = R_MLC4;
        endcase
        tap = tap + {4'd0, op.side};
        unique case (u)
            U_IN, U_OUT: begin
                if (u == U_IN)
                begin
                    op.alu  = sub[0] ? A_SET_IN : A_MUL_IN;
                    op.rsel = sub[1] ? R_VRIN : R_VLIN;
                end
                else
                begin
                    op.alu = sub[0] ? A_OUT : A_MUL_G;
                end
            end
            U_SAME_L, U_SAME_R, U_DIFF_L, U_DIFF_R: begin
                unique case (sub)
                    4'd0: begin op.mop = M_RD; op.rsel = mp; op.om = O_DEC; end
                    4'd1: begin op.mop = M_RD; op.rsel = dr; op.alu = A_PV; end
                    4'd2: begin op.alu = A_MUL_RV; op.rsel = R_VWALL; end
                    4'd3: op.alu = A_X_IN_M_PV;
                    4'd4: begin op.alu = A_MUL_X; op.rsel = R_VIIR; end
                    4'd5: op.alu = A_X_M_PV;
                    default: begin op.mop = M_WR; op.rsel = mp; end
                endcase
            end
            U_COMB_L, U_COMB_R: begin
                if (sub == 4'd8)
                    op.alu = A_X_ADD_M;
                else if (sub[0])
                begin
                    op.alu  = A_MUL_RV;
                    op.rsel = R_VC1 + {3'd0, sub[2:1]};
                end
                else
                begin
                    op.mop  = M_RD;
                    op.rsel = tap;
                    op.alu  = (sub == 4'd0) ? A_X_CLR : A_X_ADD_M;
                end
            end
            default: begin
                unique case (sub)
                    4'd0, 4'd4: begin op.mop = M_RD; op.rsel = mp; op.om = apm; end
                    4'd1: begin op.alu = A_MUL_RV; op.rsel = vap; end
                    4'd2: op.alu = A_X_SUB_M;
                    4'd3: begin op.mop = M_WR; op.rsel = mp; end
                    4'd5: begin op.alu = A_MUL_X; op.rsel = vap; end
                    default: op.alu = A_X_M_RV;
                endcase
            end
        endcase
        return op;
    endfunction

endpackage

@@ rtl/core/scar_if.sv @@
// Stream and configuration channel interfaces for the stereo reverb.
interface scar_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] left_in;
    logic [15:0] right_in;
    modport source (output valid, left_in, right_in, input ready);
    modport sink (input valid, left_in, right_in, output ready);
endinterface

interface scar_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] left_wet;
    logic [15:0] right_wet;
    modport source (output valid, left_wet, right_wet, input ready);
    modport sink (input valid, left_wet, right_wet, output ready);
endinterface

interface scar_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/stereo_comb_allpass_reverb_top.sv @@
// Stereo comb and all-pass reverb: sequencer, shared multiplier datapath, registers.
//
//  channel  dir  handshake              payload
//  in_ch    in   valid/ready            left_in, right_in
//  out_ch   out  valid/ready            left_wet, right_wet
//  cfg      in   valid/ready (always 1) index, data
//
// Each item runs 82 micro-steps, each an offset phase then an execute phase, through one
// multiplier and one buffer port, between accept and hand-off.
// After reset a zeroing sweep of all 32768 buffer words runs; in_ch.ready stays low.
// A finished result waits in the output register; the next item is taken
// meanwhile and holds in the done state until the register frees.
`include "assert_macros.svh"

module stereo_comb_allpass_reverb_top
(
    input  logic       clk,
    input  logic       rst_n,
    scar_in_if.sink    in_ch,
    scar_out_if.source out_ch,
    scar_cfg_if.sink   cfg
);

    scar_pkg::state_t            state_reg, state_next;
    scar_pkg::unit_t             unit_reg, unit_next;
    logic [3:0]                  sub_reg, sub_next;
    logic                        phase_reg, phase_next;
    logic [2:0]                  preset_reg, preset_next;
    logic [15:0]                 gain_l_reg, gain_l_next;
    logic [15:0]                 gain_r_reg, gain_r_next;
    logic [2:0]                  pidx_reg, pidx_next;
    logic [scar_pkg::ADDR_W-1:0] pos_reg, pos_next;
    logic [scar_pkg::ADDR_W-1:0] d_reg, d_next;
    logic signed [15:0]          smp_l_reg, smp_l_next;
    logic signed [15:0]          smp_r_reg, smp_r_next;
    logic signed [23:0]          inl_reg, inl_next;
    logic signed [23:0]          inr_reg, inr_next;
    logic signed [23:0]          xl_reg, xl_next;
    logic signed [23:0]          xr_reg, xr_next;
    logic signed [23:0]          m_reg, m_next;
    logic signed [15:0]          pv_reg, pv_next;
    logic signed [15:0]          res_l_reg, res_l_next;
    logic signed [15:0]          res_r_reg, res_r_next;
    logic                        out_valid_reg, out_valid_next;
    logic [15:0]                 out_l_reg, out_l_next;
    logic [15:0]                 out_r_reg, out_r_next;

    scar_pkg::uop_t              op;
    scar_pkg::wbuf_req_t         req;
    logic [15:0]                 rdata;
    logic                        clr_done;
    logic [2:0]                  cfg_pidx;
    logic [scar_pkg::ADDR_W-1:0] cur_size;
    logic [15:0]                 word;
    logic signed [19:0]          base;
    logic signed [19:0]          subv;
    logic signed [19:0]          diff;
    logic [scar_pkg::ADDR_W:0]   asum;
    logic [scar_pkg::ADDR_W:0]   pos_inc;
    logic signed [23:0]          x_side;
    logic signed [23:0]          in_side;
    logic signed [23:0]          rv;
    logic signed [23:0]          x_new;
    logic signed [23:0]          mul_a;
    logic signed [16:0]          mul_b;
    logic signed [40:0]          prod;
    logic                        in_acc;
    logic                        exec;

    scar_wbuf u_wbuf
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rdata    (rdata),
        .clr_done (clr_done)
    );

    assign in_ch.ready      = (state_reg == scar_pkg::S_IDLE) && clr_done;
    assign cfg.ready        = 1'b1;
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.left_wet  = out_l_reg;
    assign out_ch.right_wet = out_r_reg;

    assign in_acc   = in_ch.valid && in_ch.ready;
    assign exec     = (state_reg == scar_pkg::S_RUN) && phase_reg;
    assign cfg_pidx = (preset_reg == 3'd0) ? 3'd0 : preset_reg - 3'd1;
    assign cur_size = scar_pkg::ROM_SIZE[pidx_reg];
    assign op       = scar_pkg::decode(unit_reg, sub_reg);
    assign x_side   = op.side ? xr_reg : xl_reg;
    assign in_side  = op.side ? inr_reg : inl_reg;
    assign rv       = {{8{rdata[15]}}, rdata};
    assign pos_inc  = {1'b0, pos_reg} + 1'b1;

    // offset reduction, phase 0
    always_comb
    begin
        word = scar_pkg::ROM_WORDS[pidx_reg][op.rsel];
        base = {2'b00, word, 2'b00};
        unique case (op.om)
            scar_pkg::O_PLAIN: subv = 20'sd0;
            scar_pkg::O_DEC:   subv = 20'sd1;
            scar_pkg::O_AP1:   subv = {2'b00, scar_pkg::ROM_WORDS[pidx_reg][scar_pkg::R_DAPF1],
                                       2'b00};
            default:           subv = {2'b00, scar_pkg::ROM_WORDS[pidx_reg][scar_pkg::R_DAPF2],
                                       2'b00};
        endcase
        diff = base - subv;
        if (diff[19])
            diff = diff + {5'd0, cur_size};
        d_next = (state_reg == scar_pkg::S_RUN && !phase_reg) ? diff[scar_pkg::ADDR_W-1:0]
                                                              : d_reg;
    end

    // buffer address and request, phase 1
    always_comb
    begin
        asum = {1'b0, pos_reg} + {1'b0, d_reg};
        if (asum >= {1'b0, cur_size})
            asum = asum - {1'b0, cur_size};
        req.en    = exec && (op.mop != scar_pkg::M_NONE);
        req.we    = (op.mop == scar_pkg::M_WR);
        req.addr  = asum[scar_pkg::ADDR_W-1:0];
        req.wdata = scar_pkg::sat16(x_side);
    end

    // shared multiplier
    always_comb
    begin
        unique case (op.alu)
            scar_pkg::A_MUL_IN: mul_a = op.side ? {{8{smp_r_reg[15]}}, smp_r_reg}
                                                : {{8{smp_l_reg[15]}}, smp_l_reg};
            scar_pkg::A_MUL_RV: mul_a = rv;
            default:            mul_a = x_side;
        endcase
        if (op.alu == scar_pkg::A_MUL_G)
            mul_b = {1'b0, op.side ? gain_r_reg : gain_l_reg};
        else
            mul_b = {word[15], word};
        prod = mul_a * mul_b;
    end

    always_comb
    begin
        unique case (op.alu)
            scar_pkg::A_X_IN_M_PV: x_new = in_side + m_reg - {{8{pv_reg[15]}}, pv_reg};
            scar_pkg::A_X_M_PV:    x_new = m_reg + {{8{pv_reg[15]}}, pv_reg};
            scar_pkg::A_X_CLR:     x_new = 24'sd0;
            scar_pkg::A_X_ADD_M:   x_new = x_side + m_reg;
            scar_pkg::A_X_SUB_M:   x_new = x_side - m_reg;
            scar_pkg::A_X_M_RV:    x_new = m_reg + rv;
            default:               x_new = x_side;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        unit_next      = unit_reg;
        sub_next       = sub_reg;
        phase_next     = phase_reg;
        preset_next    = preset_reg;
        gain_l_next    = gain_l_reg;
        gain_r_next    = gain_r_reg;
        pidx_next      = pidx_reg;
        pos_next       = pos_reg;
        smp_l_next     = smp_l_reg;
        smp_r_next     = smp_r_reg;
        inl_next       = inl_reg;
        inr_next       = inr_reg;
        xl_next        = xl_reg;
        xr_next        = xr_reg;
        m_next         = m_reg;
        pv_next        = pv_reg;
        res_l_next     = res_l_reg;
        res_r_next     = res_r_reg;
        out_valid_next = out_valid_reg;
        out_l_next     = out_l_reg;
        out_r_next     = out_r_reg;

        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                scar_pkg::REG_PRESET: preset_next = cfg.data[2:0];
                scar_pkg::REG_GAIN_L: gain_l_next = cfg.data;
                scar_pkg::REG_GAIN_R: gain_r_next = cfg.data;
                default: ;
            endcase
        end

        if (out_valid_reg && out_ch.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            scar_pkg::S_IDLE: begin
                if (in_acc)
                begin
                    smp_l_next = in_ch.left_in;
                    smp_r_next = in_ch.right_in;
                    pidx_next  = cfg_pidx;
                    if (pos_reg >= scar_pkg::ROM_SIZE[cfg_pidx])
                        pos_next = '0;
                    unit_next  = scar_pkg::U_IN;
                    sub_next   = 4'd0;
                    phase_next = 1'b0;
                    state_next = scar_pkg::S_RUN;
                end
            end
            scar_pkg::S_RUN: begin
                phase_next = !phase_reg;
                if (phase_reg)
                begin
                    unique case (op.alu)
                        scar_pkg::A_MUL_IN, scar_pkg::A_MUL_RV, scar_pkg::A_MUL_X,
                        scar_pkg::A_MUL_G: m_next = prod[38:15];
                        scar_pkg::A_SET_IN: begin
                            if (op.side)
                                inr_next = m_reg;
                            else
                                inl_next = m_reg;
                        end
                        scar_pkg::A_PV: pv_next = rdata;
                        scar_pkg::A_OUT: begin
                            if (op.side)
                                res_r_next = scar_pkg::sat16(m_reg);
                            else
                                res_l_next = scar_pkg::sat16(m_reg);
                        end
                        scar_pkg::A_X_IN_M_PV, scar_pkg::A_X_M_PV, scar_pkg::A_X_CLR,
                        scar_pkg::A_X_ADD_M, scar_pkg::A_X_SUB_M, scar_pkg::A_X_M_RV: begin
                            if (op.side)
                                xr_next = x_new;
                            else
                                xl_next = x_new;
                        end
                        default: ;
                    endcase
                    if (sub_reg == scar_pkg::last_sub(unit_reg))
                    begin
                        sub_next = 4'd0;
                        if (unit_reg == scar_pkg::U_OUT)
                            state_next = scar_pkg::S_DONE;
                        else
                            unit_next = scar_pkg::unit_t'(unit_reg + 4'd1);
                    end
                    else
                    begin
                        sub_next = sub_reg + 4'd1;
                    end
                end
            end
            scar_pkg::S_DONE: begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_l_next     = res_l_reg;
                    out_r_next     = res_r_reg;
                    if (pos_inc >= {1'b0, cur_size})
                        pos_next = '0;
                    else
                        pos_next = pos_inc[scar_pkg::ADDR_W-1:0];
                    state_next = scar_pkg::S_IDLE;
                end
            end
            default: state_next = scar_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= scar_pkg::S_IDLE;
            unit_reg      <= scar_pkg::U_IN;
            sub_reg       <= 4'd0;
            phase_reg     <= 1'b0;
            preset_reg    <= 3'd1;
            gain_l_reg    <= 16'h8000;
            gain_r_reg    <= 16'h8000;
            pidx_reg      <= 3'd0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            unit_reg      <= unit_next;
            sub_reg       <= sub_next;
            phase_reg     <= phase_next;
            preset_reg    <= preset_next;
            gain_l_reg    <= gain_l_next;
            gain_r_reg    <= gain_r_next;
            pidx_reg      <= pidx_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg     <= d_next;
        smp_l_reg <= smp_l_next;
        smp_r_reg <= smp_r_next;
        inl_reg   <= inl_next;
        inr_reg   <= inr_next;
        xl_reg    <= xl_next;
        xr_reg    <= xr_next;
        m_reg     <= m_next;
        pv_reg    <= pv_next;
        res_l_reg <= res_l_next;
        res_r_reg <= res_r_next;
        out_l_reg <= out_l_next;
        out_r_reg <= out_r_next;
    end

    `SCAR_NEVER(a_no_accept_in_clear, in_ch.valid && in_ch.ready && !clr_done, "accept during clear")
    `SCAR_ASSERT(a_pos_in_range, (state_reg == scar_pkg::S_RUN) |-> (pos_reg < cur_size), "position out of range")
    `SCAR_ASSERT(a_out_from_done, $rose(out_valid_reg) |-> ($past(state_reg) == scar_pkg::S_DONE), "result without finished item")

endmodule

@@ rtl/core/scar_wbuf.sv @@
// Reverb work buffer: single-port RAM with a zeroing sweep after reset.
module scar_wbuf
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  scar_pkg::wbuf_req_t                req,
    output logic [15:0]                        rdata,
    output logic                               clr_done
);

    logic [15:0]                 mem [0:scar_pkg::BUFFER_DEPTH-1];
    logic [scar_pkg::ADDR_W:0]   clr_cnt_reg;
    logic [scar_pkg::ADDR_W:0]   clr_cnt_next;
    logic                        wr_en;
    logic [scar_pkg::ADDR_W-1:0] wr_addr;
    logic [15:0]                 wr_data;

    assign clr_done = clr_cnt_reg[scar_pkg::ADDR_W];

    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        if (!clr_done)
            clr_cnt_next = clr_cnt_reg + 1'b1;
        wr_en   = !clr_done || (req.en && req.we);
        wr_addr = clr_done ? req.addr : clr_cnt_reg[scar_pkg::ADDR_W-1:0];
        wr_data = clr_done ? req.wdata : 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else
            clr_cnt_reg <= clr_cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (clr_done && req.en && !req.we)
            rdata <= mem[req.addr];
    end

endmodule

@@ verif/stereo_reverb_checker.sv @@
// Checker for the stereo reverb: watches the channels, predicts each wet sample pair, compares.
`timescale 1ns / 1ps

module stereo_reverb_checker
    import scar_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    scar_in_if         in_ch,
    scar_out_if        out_ch,
    scar_cfg_if        cfg,
    output int         errors,
    output int         wet_pending,
    output int         wet_checked
);

    typedef struct {
        logic [15:0] left;
        logic [15:0] right;
    } wet_pair_t;

    wet_pair_t         wet_q[$];
    logic signed [15:0] work_mem [0:BUFFER_DEPTH-1];
    int                buf_pos;
    logic [2:0]        preset_q;
    logic [15:0]       gain_l;
    logic [15:0]       gain_r;
    int                psel;
    int                sz;
    int                cur;

    function automatic longint vq(int r);
        logic [15:0] w;
        w = ROM_WORDS[psel][r];
        return longint'($signed(w));
    endfunction

    function automatic int offs(int r);
        return (int'(ROM_WORDS[psel][r]) * 4) % sz;
    endfunction

    function automatic int dec_off(int o, int d);
        return (o + sz - d) % sz;
    endfunction

    function automatic longint mq(longint a, longint v);
        return (a * v) >>> 15;
    endfunction

    function automatic logic signed [15:0] clip(longint x);
        if (x > 32767)
            return 16'sh7fff;
        if (x < -32768)
            return 16'sh8000;
        return x[15:0];
    endfunction

    function automatic longint rdw(int o);
        return longint'(work_mem[(cur + o) % sz]);
    endfunction

    function automatic void wrw(int o, longint x);
        work_mem[(cur + o) % sz] = clip(x);
    endfunction

    function automatic void predict_wet(logic [15:0] li, logic [15:0] ri);
        longint    lin, rin, pl, pr, lo, ro, vw, vi, va1, va2;
        int        la1, ra1, la2, ra2;
        wet_pair_t w;
        psel = (preset_q == 3'd0) ? 0 : int'(preset_q) - 1;
        sz   = int'(ROM_SIZE[psel]);
        if (buf_pos >= sz)
            buf_pos = 0;
        cur = buf_pos;
        vw  = vq(R_VWALL);
        vi  = vq(R_VIIR);
        va1 = vq(R_VAPF1);
        va2 = vq(R_VAPF2);
        la1 = dec_off(offs(R_MLAPF1), offs(R_DAPF1));
        ra1 = dec_off(offs(R_MRAPF1), offs(R_DAPF1));
        la2 = dec_off(offs(R_MLAPF2), offs(R_DAPF2));
        ra2 = dec_off(offs(R_MRAPF2), offs(R_DAPF2));
        lin = mq(longint'($signed(li)), vq(R_VLIN));
        rin = mq(longint'($signed(ri)), vq(R_VRIN));

        pl = rdw(dec_off(offs(R_MLSAME), 1));
        pr = rdw(dec_off(offs(R_MRSAME), 1));
        wrw(offs(R_MLSAME), mq(lin + mq(rdw(offs(R_DLSAME)), vw) - pl, vi) + pl);
        wrw(offs(R_MRSAME), mq(rin + mq(rdw(offs(R_DRSAME)), vw) - pr, vi) + pr);
        pl = rdw(dec_off(offs(R_MLDIFF), 1));
        pr = rdw(dec_off(offs(R_MRDIFF), 1));
        wrw(offs(R_MLDIFF), mq(lin + mq(rdw(offs(R_DRDIFF)), vw) - pl, vi) + pl);
        wrw(offs(R_MRDIFF), mq(rin + mq(rdw(offs(R_DLDIFF)), vw) - pr, vi) + pr);

        lo = mq(rdw(offs(R_MLC1)), vq(R_VC1)) + mq(rdw(offs(R_MLC2)), vq(R_VC1 + 1))
           + mq(rdw(offs(R_MLC3)), vq(R_VC1 + 2)) + mq(rdw(offs(R_MLC4)), vq(R_VC1 + 3));
        ro = mq(rdw(offs(R_MLC1 + 1)), vq(R_VC1)) + mq(rdw(offs(R_MLC2 + 1)), vq(R_VC1 + 1))
           + mq(rdw(offs(R_MLC3 + 1)), vq(R_VC1 + 2))
           + mq(rdw(offs(R_MLC4 + 1)), vq(R_VC1 + 3));

        lo -= mq(rdw(la1), va1);
        wrw(offs(R_MLAPF1), lo);
        lo = mq(lo, va1) + rdw(la1);
        ro -= mq(rdw(ra1), va1);
        wrw(offs(R_MRAPF1), ro);
        ro = mq(ro, va1) + rdw(ra1);
        lo -= mq(rdw(la2), va2);
        wrw(offs(R_MLAPF2), lo);
        lo = mq(lo, va2) + rdw(la2);
        ro -= mq(rdw(ra2), va2);
        wrw(offs(R_MRAPF2), ro);
        ro = mq(ro, va2) + rdw(ra2);

        w.left  = clip(mq(lo, longint'(gain_l)));
        w.right = clip(mq(ro, longint'(gain_r)));
        wet_q.push_back(w);
        buf_pos = cur + 1;
        if (buf_pos >= sz)
            buf_pos = 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        wet_pair_t w;
        if (!rst_n)
        begin
            for (int i = 0; i < BUFFER_DEPTH; i++)
                work_mem[i] = '0;
            buf_pos  = 0;
            preset_q = 3'd1;
            gain_l   = 16'h8000;
            gain_r   = 16'h8000;
            wet_q.delete();
            errors      <= 0;
            wet_checked <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_PRESET)
                    preset_q = cfg.data[2:0];
                else if (cfg.index == REG_GAIN_L)
                    gain_l = cfg.data;
                else if (cfg.index == REG_GAIN_R)
                    gain_r = cfg.data;
            end
            if (in_ch.valid && in_ch.ready)
                predict_wet(in_ch.left_in, in_ch.right_in);
            if (out_ch.valid && out_ch.ready)
            begin
                wet_checked <= wet_checked + 1;
                if (wet_q.size() == 0)
                begin
                    $error("wet beat with no expectation waiting");
                    errors <= errors + 1;
                end
                else
                begin
                    w = wet_q.pop_front();
                    if (out_ch.left_wet !== w.left || out_ch.right_wet !== w.right)
                        errors <= errors + 1;
                    if (out_ch.left_wet !== w.left)
                        $error("left_wet: expected %0d, got %0d",
                               $signed(w.left), $signed(out_ch.left_wet));
                    if (out_ch.right_wet !== w.right)
                        $error("right_wet: expected %0d, got %0d",
                               $signed(w.right), $signed(out_ch.right_wet));
                end
            end
        end
        wet_pending <= wet_q.size();
    end

endmodule

@@ verif/tb_stereo_comb_allpass_reverb_top.sv @@
// Testbench top for the stereo reverb: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb_stereo_comb_allpass_reverb_top;
    import scar_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_ITEMS = 600;

    logic clk;
    logic rst_n;
    int   errors;
    int   wet_pending;
    int   wet_checked;
    int   cycles;
    int   tx_idle;
    int   rx_idle;
    int   hold_cycles;
    int   items_sent;
    int   cfg_writes;

    scar_in_if  in_ch();
    scar_out_if out_ch();
    scar_cfg_if cfg();

    stereo_comb_allpass_reverb_top dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    stereo_reverb_checker chk
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg         (cfg),
        .errors      (errors),
        .wet_pending (wet_pending),
        .wet_checked (wet_checked)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_stereo_comb_allpass_reverb_top: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= rx_idle);
    end

    task automatic send_sample(input logic [15:0] l, input logic [15:0] r);
        while ($urandom_range(99) < tx_idle)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.left_in  <= l;
        in_ch.right_in <= r;
        do
            @(posedge clk);
        while (!in_ch.ready);
        items_sent++;
    endtask

    task automatic drain;
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (wet_pending != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        @(posedge clk);
        cfg_writes++;
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(3))
            0:       return 16'h0000;
            1:       return 16'hffff;
            2:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(9))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'($signed(16'($urandom_range(255))) - 128);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [15:0] edge_vals [0:4];
        edge_vals = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001};
        cycles = 0;
        tx_idle = 12;
        rx_idle = 86;
        hold_cycles = 0;
        items_sent = 0;
        cfg_writes = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.left_in = '0;
        in_ch.right_in = '0;
        out_ch.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = REG_PRESET;
        cfg.data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (edge_vals[i])
            foreach (edge_vals[j])
                if (i < 4)
                    send_sample(edge_vals[i], edge_vals[j]);
        drain();
        write_reg(REG_PRESET, 16'd0);
        write_reg(REG_GAIN_L, 16'hffff);
        write_reg(REG_GAIN_R, 16'h0000);
        write_reg(2'd3, 16'hffff);
        repeat (3) send_sample(16'h7fff, 16'h8000);
        send_sample(16'h8000, 16'h7fff);
        drain();
        write_reg(REG_PRESET, 16'd7);
        write_reg(REG_GAIN_L, 16'h0000);
        write_reg(REG_GAIN_R, 16'hffff);
        send_sample(16'h8000, 16'h7fff);
        send_sample(16'h7fff, 16'h8000);

        hold_cycles = 2000;
        repeat (6) send_sample(pick_sample(), pick_sample());

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 200)
            begin
                tx_idle = 86;
                rx_idle = 12;
            end
            if (n == 400)
            begin
                tx_idle = 0;
                rx_idle = 0;
            end
            if (n % 60 == 59)
            begin
                drain();
                write_reg(REG_PRESET, 16'($urandom_range(7)));
                write_reg(REG_GAIN_L, pick_gain());
                write_reg(REG_GAIN_R, pick_gain());
            end
            send_sample(pick_sample(), pick_sample());
        end
        drain();

        $display("covered %0d sample pairs, %0d wet beats, %0d register writes",
                 items_sent, wet_checked, cfg_writes);
        $display("presets swept with gain extremes under three stall mixes and a long hold-off");
        if (errors == 0)
            $display("tb_stereo_comb_allpass_reverb_top: PASS");
        else
            $display("tb_stereo_comb_allpass_reverb_top: FAIL");
        $finish;
    end

endmodule
